FILE: rtl/core/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types and codes for the 1-Wire search ROM engine.
// ----------------------------------------------------------------------------
package ors_pkg;

    localparam int RomBits  = 64;
    localparam int RomBytes = 8;
    localparam int EndCount = 65;
    localparam int IdxW     = 7;
    localparam int PosW     = 6;

    typedef enum logic [1:0] {
        CMD_FIRST   = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_VERIFY  = 2'd2,
        CMD_TRIPLET = 2'd3
    } t_ors_cmd;

    typedef enum logic [1:0] {
        ST_CONTINUE  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NO_DEVICE = 2'd2,
        ST_IDLE      = 2'd3
    } t_ors_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] target_rom;
        logic        id_bit;
        logic        complement_bit;
    } t_ors_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_bit;
        logic [6:0]  bit_index;
        logic [63:0] rom_code;
        logic        done_res;
    } t_ors_out;

    typedef struct packed {
        logic [63:0]     work_rom;
        logic [63:0]     verify_target;
        logic [IdxW-1:0] last_disc;
        logic            last_dev;
        logic [IdxW-1:0] zero_mark;
        logic [IdxW-1:0] bit_cnt;
        logic            searching;
        logic            verifying;
    } t_ors_state;

endpackage

FILE: rtl/core/ors_step.sv
// ----------------------------------------------------------------------------
// ors_step
// Decision logic for one item: next search state and the result item.
// ----------------------------------------------------------------------------
module ors_step (
    input  ors_pkg::t_ors_in    i_item,
    input  ors_pkg::t_ors_state i_state,
    output ors_pkg::t_ors_state o_state,
    output ors_pkg::t_ors_out   o_result
);
    import ors_pkg::*;

    t_ors_cmd                cmd;
    t_ors_state              n_state;
    logic [IdxW-1:0]         bit_n;
    logic [IdxW-1:0]         bit_m1;
    logic [PosW-1:0]         pos;
    logic [IdxW:0]           bit_p1;
    logic                    dir;
    logic [RomBits-1:0]      mask;

    assign cmd    = t_ors_cmd'(i_item.command);
    assign bit_n  = i_state.bit_cnt;
    assign bit_m1 = bit_n - IdxW'(1);
    assign pos    = bit_m1[PosW-1:0];
    assign bit_p1 = {1'b0, bit_n} + (IdxW+1)'(1);
    assign mask   = RomBits'(1) << pos;

    always_comb begin
        n_state            = i_state;
        o_result.status    = ST_IDLE;
        o_result.write_bit = 1'b0;
        o_result.bit_index = '0;
        o_result.done_res  = 1'b0;
        dir                = 1'b0;

        case (cmd)
            CMD_FIRST, CMD_NEXT: begin
                if (cmd == CMD_FIRST) begin
                    n_state.last_disc = '0;
                    n_state.last_dev  = 1'b0;
                end
                n_state.verifying = 1'b0;
                n_state.bit_cnt   = IdxW'(1);
                if (n_state.last_dev) begin
                    n_state.searching = 1'b0;
                    o_result.status   = ST_NO_DEVICE;
                    o_result.done_res = 1'b1;
                end else begin
                    n_state.zero_mark = '0;
                    n_state.searching = 1'b1;
                    o_result.status   = ST_CONTINUE;
                end
            end
            CMD_VERIFY: begin
                n_state.last_disc     = IdxW'(RomBits);
                n_state.last_dev      = 1'b0;
                n_state.verify_target = i_item.target_rom;
                n_state.work_rom      = i_item.target_rom;
                n_state.verifying     = 1'b1;
                n_state.bit_cnt       = IdxW'(1);
                n_state.zero_mark     = '0;
                n_state.searching     = 1'b1;
                o_result.status       = ST_CONTINUE;
            end
            CMD_TRIPLET: begin
                if (i_state.searching) begin
                    // Below the last discrepancy repeat the stored bit, at it take 1.
                    if (bit_n < i_state.last_disc) begin
                        dir = i_state.work_rom[pos];
                    end else begin
                        dir = (bit_n == i_state.last_disc);
                    end
                    if (i_item.id_bit && i_item.complement_bit) begin
                        n_state.searching  = 1'b0;
                        n_state.verifying  = 1'b0;
                        n_state.bit_cnt    = IdxW'(1);
                        o_result.status    = ST_NO_DEVICE;
                        o_result.write_bit = 1'b1;
                        o_result.bit_index = bit_n;
                        o_result.done_res  = 1'b1;
                    end else begin
                        if (i_item.id_bit != i_item.complement_bit) begin
                            dir = i_item.id_bit;
                        end else if (!dir) begin
                            n_state.zero_mark = bit_n;
                        end
                        if (dir) begin
                            n_state.work_rom = i_state.work_rom | mask;
                        end else begin
                            n_state.work_rom = i_state.work_rom & ~mask;
                        end
                        o_result.write_bit = dir;
                        if (bit_p1 >= (IdxW+1)'(EndCount)) begin
                            n_state.last_disc = n_state.zero_mark;
                            n_state.last_dev  = (n_state.zero_mark == '0);
                            n_state.searching = 1'b0;
                            n_state.verifying = 1'b0;
                            n_state.bit_cnt   = IdxW'(1);
                            if (i_state.verifying &&
                                (n_state.work_rom != i_state.verify_target)) begin
                                o_result.status = ST_NO_DEVICE;
                            end else begin
                                o_result.status = ST_FOUND;
                            end
                            o_result.bit_index = IdxW'(RomBits);
                            o_result.done_res  = 1'b1;
                        end else begin
                            n_state.bit_cnt    = bit_p1[IdxW-1:0];
                            o_result.status    = ST_CONTINUE;
                            o_result.bit_index = bit_n;
                        end
                    end
                end
            end
            default: begin
                n_state = i_state;
            end
        endcase
        o_result.rom_code = n_state.work_rom;
        o_state           = n_state;
    end

endmodule

FILE: rtl/core/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire search ROM decision engine: direction bits, ROM code and end status.
// ----------------------------------------------------------------------------
//  Channel   Valid         Ready         Item
//  in        i_in_valid    o_in_ready    i_in_item  (command, target, triplet bits)
//  out       o_out_valid   i_out_ready   o_out_item (status, bit, index, ROM, done)
//
// The block takes one item per cycle while the output is not stalled; each
// accepted item passes through the input register and then the result register.
// The search state is updated when an item moves from the input register
// into the result register, so the following item sees it at once.
// Reset (synchronous, active low) clears both stages and the search state.
// A stalled output holds its item; the input register keeps filling while
// the result register is free or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module onewire_rom_search (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ors_pkg::t_ors_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ors_pkg::t_ors_out o_out_item
);
    import ors_pkg::*;

    // Input stage: holds the accepted item for the decision logic.
    logic       r_in_valid;
    t_ors_in    r_in_item;

    // Result stage.
    logic       r_out_valid;
    t_ors_out   r_out_item;

    // Search state: ROM code, marks, bit counter and mode flags.
    t_ors_state r_state;
    t_ors_state n_state;
    t_ors_out   n_result;

    logic       in_fire;
    logic       step_fire;

    // The decision step runs when the result register can take its result.
    assign step_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_in_valid || step_fire;

    ors_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_item <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.work_rom      <= '0;
            r_state.verify_target <= '0;
            r_state.last_disc     <= '0;
            r_state.last_dev      <= 1'b0;
            r_state.zero_mark     <= '0;
            r_state.bit_cnt       <= IdxW'(1);
            r_state.searching     <= 1'b0;
            r_state.verifying     <= 1'b0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // While a search runs, the counter names a real ROM bit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.searching |-> (r_state.bit_cnt >= IdxW'(1) &&
                               r_state.bit_cnt <= IdxW'(RomBits)))
        else $error("bit counter out of range during search");

    // A verify is always a kind of search.
    a_verify_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.verifying |-> r_state.searching)
        else $error("verify flag set without a running search");

    // The last device is only flagged when no discrepancy is left.
    a_last_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.last_dev |-> (r_state.last_disc == '0))
        else $error("last device flag with a pending discrepancy");

    // A continuing result never claims the search has ended.
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status == ST_CONTINUE) |-> !r_out_item.done_res)
        else $error("done result with continue status");

    // After a step the state counter restarts whenever the result ends a pass.
    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && n_result.done_res) |=> (!r_state.searching &&
                                              r_state.bit_cnt == IdxW'(1)))
        else $error("finished pass left the search running");

endmodule
